/* hdl/uct_pkg.sv */
// Package with widths, constants and pipeline types of the upwind convection axis term.
package uct_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SP_W   = 31;
  localparam int unsigned S_W    = 37;
  localparam int unsigned SM_W   = 36;
  localparam int unsigned DEN_W  = 35;
  localparam int unsigned PROD_W = 68;
  localparam int unsigned QW     = 32;

  localparam logic [QW-1:0] POS_LIMIT = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIMIT = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    num;
    logic [QW-1:0]    quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             big;
    logic             pz;
  } div_st_t;

endpackage

/* hdl/uct_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface uct_in_if
  import uct_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_center;
  logic signed [VAL_W-1:0] value_ahead_one;
  logic signed [VAL_W-1:0] value_ahead_two;
  logic signed [VAL_W-1:0] value_behind_one;
  logic signed [VAL_W-1:0] value_behind_two;
  logic signed [VAL_W-1:0] advect_velocity;
  logic [SP_W-1:0]         cell_spacing;

  modport source (output valid, value_center, value_ahead_one, value_ahead_two,
                  value_behind_one, value_behind_two, advect_velocity, cell_spacing,
                  input ready);
  modport sink (input valid, value_center, value_ahead_one, value_ahead_two,
                value_behind_one, value_behind_two, advect_velocity, cell_spacing,
                output ready);
endinterface

interface uct_out_if
  import uct_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] axis_term;
  logic                    saturated;

  modport source (output valid, axis_term, saturated, input ready);
  modport sink (input valid, axis_term, saturated, output ready);
endinterface

/* hdl/uct_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation and output register.
module uct_div
  import uct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  div_st_t                 in_st,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_term,
  output logic                    out_sat
);

  logic    v_r  [QW];
  div_st_t st_r [QW];
  logic    out_v_r;
  logic [VAL_W-1:0] term_r;
  logic             sat_r;

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t          r;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   d;
    r = s;
    t = {s.rem, s.num[QW-1]};
    d = t - {1'b0, s.den};
    r.num = {s.num[QW-2:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      r.rem = d[DEN_W-1:0];
      r.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = t[DEN_W-1:0];
      r.quo = {s.quo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  for (genvar k = 0; k < QW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= div_step((k == 0) ? in_st : st_r[(k == 0) ? 0 : k-1]);
      end
    end
  end

  div_st_t          last;
  logic             sat_nxt;
  logic [VAL_W-1:0] term_nxt;

  always_comb begin
    last = st_r[QW-1];
    if (last.den == '0 && last.pz) begin
      sat_nxt  = 1'b0;
      term_nxt = '0;
    end else if (last.neg) begin
      sat_nxt  = last.big || (last.quo > NEG_LIMIT);
      term_nxt = sat_nxt ? NEG_LIMIT : (~last.quo + 1'b1);
    end else begin
      sat_nxt  = last.big || last.quo[QW-1];
      term_nxt = sat_nxt ? POS_LIMIT : last.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_term  = term_r;
  assign out_sat   = sat_r;

endmodule

/* hdl/upwind_convection_axis_term.sv */
// Top level of the upwind convection axis term pipeline.
//
// Usage: one input transfer on in_ch carries the five field values along
// one axis, the advecting velocity and the cell spacing. For each input
// transfer exactly one result transfer appears on out_ch, in order, with
// the axis term (u*S)/(12*d) truncated toward zero and saturated to the
// signed 32-bit range, plus a flag that marks clipping.
// Throughput: one transfer per cycle while out_ch does not stall the pipeline.
// Stages from input transfer to result valid: stencil sum, split multiply, product sum,
// range check, then 32 divider stages of one quotient bit each, then the
// saturation and output register. The 32-stage divider sets the depth.
// Reset (rst_n low, synchronous) clears all valid bits; no result is
// pending afterwards. When the receiver holds out_ch.ready low while a
// result is valid, the whole pipeline freezes and in_ch.ready drops, so
// nothing is lost or repeated; a bubble in the output register lets the
// pipeline keep moving even while ready is low.
module upwind_convection_axis_term
  import uct_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  uct_in_if.sink    in_ch,
  uct_out_if.source out_ch
);

  logic en;
  logic div_out_valid;

  // The pipeline advances whenever the output register is empty or drained.
  assign en          = !div_out_valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: upwind-selected stencil sum, velocity magnitude, denominator.
  logic signed [S_W-1:0] c_x, a1_x, a2_x, b1_x, b2_x, s_nxt;
  logic                  va_r;
  logic signed [S_W-1:0] s_r;
  logic [VAL_W-1:0]      um_r;
  logic                  uneg_r;
  logic [DEN_W-1:0]      den_r;

  always_comb begin
    c_x  = S_W'(in_ch.value_center);
    a1_x = S_W'(in_ch.value_ahead_one);
    a2_x = S_W'(in_ch.value_ahead_two);
    b1_x = S_W'(in_ch.value_behind_one);
    b2_x = S_W'(in_ch.value_behind_two);
    if (!in_ch.advect_velocity[VAL_W-1]) begin
      s_nxt = (a1_x <<< 2) + (c_x <<< 2) + (c_x <<< 1) - (b1_x <<< 3) - (b1_x <<< 2)
              + (b2_x <<< 1);
    end else begin
      s_nxt = (a1_x <<< 3) + (a1_x <<< 2) - (a2_x <<< 1) - (c_x <<< 2) - (c_x <<< 1)
              - (b1_x <<< 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_nxt;
      uneg_r <= in_ch.advect_velocity[VAL_W-1];
      um_r   <= in_ch.advect_velocity[VAL_W-1] ? (~in_ch.advect_velocity + 1'b1)
                                               : in_ch.advect_velocity;
      den_r  <= (DEN_W'(in_ch.cell_spacing) << 3) + (DEN_W'(in_ch.cell_spacing) << 2);
    end
  end

  // Stage B: magnitude product split into a 32x32 and a 32x4 partial product.
  logic [SM_W-1:0]  sm;
  logic             vb_r;
  logic [63:0]      t0_r;
  logic [35:0]      t1_r;
  logic             negb_r;
  logic [DEN_W-1:0] denb_r;

  assign sm = s_r[S_W-1] ? SM_W'(-s_r) : SM_W'(s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r   <= 64'(um_r) * 64'(sm[31:0]);
      t1_r   <= 36'(um_r) * 36'(sm[SM_W-1:32]);
      negb_r <= uneg_r ^ s_r[S_W-1];
      denb_r <= den_r;
    end
  end

  // Stage C: full product.
  logic              vc_r;
  logic [PROD_W-1:0] p_r;
  logic              negc_r;
  logic [DEN_W-1:0]  denc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= PROD_W'(t0_r) + (PROD_W'(t1_r) << 32);
      negc_r <= negb_r;
      denc_r <= denb_r;
    end
  end

  // Stage D: a high half at or above the divisor means a quotient of 2^32
  // or more, which saturates; otherwise the high half is the first remainder.
  logic [PROD_W-33:0] hi;
  logic               big;
  logic               vd_r;
  div_st_t            std_r;

  assign hi  = p_r[PROD_W-1:32];
  assign big = hi >= (PROD_W-32)'(denc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      std_r.rem <= big ? '0 : hi[DEN_W-1:0];
      std_r.num <= p_r[31:0];
      std_r.quo <= '0;
      std_r.den <= denc_r;
      std_r.neg <= negc_r;
      std_r.big <= big;
      std_r.pz  <= (p_r == '0);
    end
  end

  uct_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vd_r),
    .in_st     (std_r),
    .out_valid (div_out_valid),
    .out_term  (out_ch.axis_term),
    .out_sat   (out_ch.saturated)
  );

  assign out_ch.valid = div_out_valid;

  // A clipped result is always one of the two range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (out_ch.axis_term == POS_LIMIT) || (out_ch.axis_term == NEG_LIMIT))
    else $error("saturated result is not a range limit");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A stall freezes the first stage's item.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && !en |=> va_r && $stable(s_r) && $stable(den_r))
    else $error("first stage item changed during stall");

endmodule

/* test/tb_upwind_convection_axis_term.sv */
// Self-checking testbench for the upwind convection axis term pipeline.
module tb_upwind_convection_axis_term
  import uct_pkg::*;
;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  uct_in_if  in_ch ();
  uct_out_if out_ch ();

  upwind_convection_axis_term DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One expected result: the term and its clipping flag.
  typedef struct {
    logic signed [VAL_W-1:0] term;
    logic                    clip;
  } term_t;

  term_t expected_terms[$];
  int    error_count = 0;
  bit    calm = 1'b0;   // when set, neither side inserts idle cycles

  // Predicts the axis term. The stencil is folded into u*S by the sign of u;
  // the quotient is truncated toward zero and then clipped to 32 bits.
  function automatic term_t predict_term(
      logic signed [31:0] c, logic signed [31:0] a1, logic signed [31:0] a2,
      logic signed [31:0] b1, logic signed [31:0] b2, logic signed [31:0] u,
      logic [30:0] d);
    logic signed [39:0]  s;
    logic [35:0]         um;
    logic [39:0]         sm;
    logic [79:0]         prod;
    logic [79:0]         den;
    logic [79:0]         quo;
    logic                neg;
    term_t               r;
    if (u >= 0)
      s = 4 * 40'(a1) + 6 * 40'(c) - 12 * 40'(b1) + 2 * 40'(b2);
    else
      s = -2 * 40'(a2) + 12 * 40'(a1) - 6 * 40'(c) - 4 * 40'(b1);
    um   = (u < 0) ? 36'(-36'(signed'(u))) : 36'(u);
    sm   = (s < 0) ? -s : s;
    neg  = (u < 0) != (s < 0);
    prod = 80'(um) * 80'(sm);
    den  = 80'(d) * 80'd12;
    r.clip = 1'b0;
    if (den == 0) begin
      // Zero spacing: a zero numerator yields zero, anything else clips.
      if (prod == 0) begin
        r.term = '0;
        return r;
      end
      quo = '1;
    end else begin
      quo = prod / den;
    end
    if (neg) begin
      if (quo > 80'd2147483648) begin
        r.term = NEG_LIMIT;
        r.clip = 1'b1;
      end else begin
        r.term = 32'(-quo);
      end
    end else begin
      if (quo > 80'd2147483647) begin
        r.term = POS_LIMIT;
        r.clip = 1'b1;
      end else begin
        r.term = 32'(quo);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Sends one item: optional idle burst, then holds valid until the transfer.
  task automatic send_cell(input logic [31:0] c, input logic [31:0] a1,
                           input logic [31:0] a2, input logic [31:0] b1,
                           input logic [31:0] b2, input logic [31:0] u,
                           input logic [30:0] d);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.value_center     <= c;
    in_ch.value_ahead_one  <= a1;
    in_ch.value_ahead_two  <= a2;
    in_ch.value_behind_one <= b1;
    in_ch.value_behind_two <= b2;
    in_ch.advect_velocity  <= u;
    in_ch.cell_spacing     <= d;
    do @(posedge clk); while (!in_ch.ready);
    // The transfer happened at this edge; queue its prediction.
    expected_terms.push_back(predict_term(c, a1, a2, b1, b2, u, d));
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // Picks a field value, leaning toward extremes now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2) - 1;
      3: return 32'(signed'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_spacing();
    case ($urandom_range(0, 7))
      0: return 31'h7FFF_FFFF;
      1: return 31'd1;
      2: return 31'd0;
      3: return 31'($urandom_range(1, 32'h0002_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  // Receiver: stalls in random bursts, checks every result transfer in order.
  initial begin : result_checker
    term_t want;
    int    stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_terms.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = expected_terms.pop_front();
          if (out_ch.axis_term !== want.term)
            report_mismatch($sformatf("axis_term got %h want %h",
                                      out_ch.axis_term, want.term));
          if (out_ch.saturated !== want.clip)
            report_mismatch($sformatf("saturated got %b want %b",
                                      out_ch.saturated, want.clip));
        end
      end
    end
  end

  // Field extremes on every input, each velocity sign and zero velocity.
  task automatic test_extremes();
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
    send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
    send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_cell('1, '1, '1, '1, '1, '1, 31'h7FFF_FFFF);
    send_cell('0, '0, '0, '0, '0, '0, 31'd1);
    send_cell(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_8000,
              32'h0000_4000, 32'h0000_0000, 31'h0001_0000);
    send_cell(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_8000,
              32'h0000_4000, 32'hFFFF_0000, 31'h0001_0000);
  endtask

  // Truncation toward zero for both signs of the velocity.
  task automatic test_rounding();
    send_cell(32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 31'd1);
    send_cell(32'd0, 32'd1, 32'd0, 32'd0, 32'd0, -32'sd1, 31'd1);
    send_cell(32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'd7, 31'd3);
    send_cell(32'd5, 32'd0, 32'd0, 32'd0, 32'd0, -32'sd7, 31'd3);
  endtask

  // Overflow to the positive limit from either velocity sign, and the exact negative limit without clipping.
  task automatic test_overflow();
    send_cell(32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 31'd1);
    send_cell(32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 31'd1);
    // u = 2^31 negative, S = -6c with c = -2: u*S / 12 = -2^31 exactly.
    send_cell(-32'sd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 31'd1);
    send_cell(32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 31'd1);
  endtask

  // Zero spacing: zero numerator gives zero, otherwise clip toward the sign.
  task automatic test_zero_spacing();
    send_cell(32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd0, 31'd0);
    send_cell(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5, 31'd0);
    send_cell(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5, 31'd0);
    send_cell(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, -32'sd5, 31'd0);
  endtask

  task automatic test_random(input int count);
    repeat (count)
      send_cell(pick_value(), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_spacing());
  endtask

  initial begin : stimulus
    int drain;
    in_ch.valid            <= 1'b0;
    in_ch.value_center     <= '0;
    in_ch.value_ahead_one  <= '0;
    in_ch.value_ahead_two  <= '0;
    in_ch.value_behind_one <= '0;
    in_ch.value_behind_two <= '0;
    in_ch.advect_velocity  <= '0;
    in_ch.cell_spacing     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_rounding();
    test_overflow();
    test_zero_spacing();
    test_random(600);
    // The last stretch runs back to back on both sides.
    calm = 1'b1;
    test_random(100);
    drop_valid();
    drain = 0;
    while (expected_terms.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_terms.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
